@@ rtl/bucket_priority_deque_core_macros.svh @@
// Assertion macros for the bucket priority deque core.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef BUCKET_PRIORITY_DEQUE_CORE_MACROS_SVH
`define BUCKET_PRIORITY_DEQUE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bucket queue check failed");

// next-cycle implication, disabled during reset
`define BPD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bucket queue check failed");

`endif

@@ rtl/bpd_pkg.sv @@
// Shared types and constants of the bucket priority deque core.
// Used by bpd_ctrl, bpd_store and bucket_priority_deque_core; depends on nothing.
`default_nettype none

package bpd_pkg;

	localparam int NUM_BUCKETS  = 32;
	localparam int BUCKET_DEPTH = 32;
	localparam int COORD_BITS   = 8;

	localparam int BKT_W   = $clog2(NUM_BUCKETS);
	localparam int SLOT_W  = $clog2(BUCKET_DEPTH);
	localparam int CNT_W   = $clog2(BUCKET_DEPTH + 1);
	localparam int ADDR_W  = BKT_W + SLOT_W;
	localparam int ENTRY_W = 2 * COORD_BITS;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP_NEW = 2'd1,
		ACT_POP_OLD = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic             pop_ok;
		logic [BKT_W-1:0] bucket;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/bucket_priority_deque_core.sv @@
// Top level of the bucket priority deque core: ties the pointer control to the entry memory.
// Depends on bpd_pkg, bpd_ctrl, bpd_store and bucket_priority_deque_core_macros.svh.
//
// The core accepts one transaction (push, pop newest, pop oldest, clear) in every cycle;
// busy is never raised. Each transaction gives exactly one result, shown on status, out_x,
// out_y and out_bucket for one cycle while done is high; done and the result are driven by
// the result register, behind the input register that accepted the transaction. The
// pointer update sits between the input register and the result register; the entry
// memory read is registered at the same edge as the result. Results cannot be held off,
// so the receiver must take every done cycle. Entry contents are not cleared at reset or
// by a clear; only entries written by a push are ever returned.
`default_nettype none
`include "bucket_priority_deque_core_macros.svh"

module bucket_priority_deque_core
	import bpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] action,
	input  wire logic [7:0] priority_req,
	input  wire logic [7:0] coord_x,
	input  wire logic [7:0] coord_y,
	output logic            done,
	output logic [1:0]      status,
	output logic [7:0]      out_x,
	output logic [7:0]      out_y,
	output logic [4:0]      out_bucket
);

	mem_req_t           mem_req;
	result_t            res;
	logic [ENTRY_W-1:0] rdata;
	logic [7:0]         bucket8;
	logic               fail_done;
	logic               data_zero;

	bpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.priority_req (priority_req),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.mem_req      (mem_req),
		.res          (res)
	);

	bpd_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	assign bucket8    = 8'(res.bucket);
	assign busy       = 1'b0;
	assign done       = res.valid;
	assign status     = res.status;
	assign out_x      = res.pop_ok ? 8'(rdata[ENTRY_W-1:COORD_BITS]) : '0;
	assign out_y      = res.pop_ok ? 8'(rdata[COORD_BITS-1:0]) : '0;
	assign out_bucket = res.pop_ok ? bucket8[4:0] : '0;

	assign fail_done = done && (status != ST_DONE);
	assign data_zero = (out_x == '0) && (out_y == '0) && (out_bucket == '0);

	`BPD_ASSERT_IMP(a_fail_zero_data, clk, arst_n, fail_done, data_zero)
	`BPD_ASSERT_IMP(a_pop_means_done, clk, arst_n, done && res.pop_ok, status == ST_DONE)

endmodule

`default_nettype wire

@@ rtl/bpd_store.sv @@
// Entry memory of the bucket priority deque: one write and one registered read per cycle.
// Depends on bpd_pkg.
`default_nettype none

module bpd_store
	import bpd_pkg::*;
(
	input  wire logic               clk,
	input  wire mem_req_t           req,
	output logic      [ENTRY_W-1:0] rdata
);

	localparam int MEM_DEPTH = 1 << ADDR_W;

	logic [ENTRY_W-1:0] mem [0:MEM_DEPTH-1];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bpd_ctrl.sv @@
// Input register, per-bucket ring pointers and counts, lowest-bucket search and result register.
// Depends on bpd_pkg and bucket_priority_deque_core_macros.svh.
`default_nettype none
`include "bucket_priority_deque_core_macros.svh"

module bpd_ctrl
	import bpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] action,
	input  wire logic [7:0] priority_req,
	input  wire logic [7:0] coord_x,
	input  wire logic [7:0] coord_y,
	output mem_req_t        mem_req,
	output result_t         res
);

	logic            v_s1;
	action_t         act_s1;
	logic [7:0]      prio_s1;
	logic [7:0]      x_s1;
	logic [7:0]      y_s1;

	logic [SLOT_W-1:0] head_q [NUM_BUCKETS];
	logic [SLOT_W-1:0] tail_q [NUM_BUCKETS];
	logic [CNT_W-1:0]  cnt_q  [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] ne_q;
	result_t           res_q;

	logic [NUM_BUCKETS-1:0] low_hot;
	logic [BKT_W-1:0]  fb;
	logic [BKT_W-1:0]  sel;
	logic              found;
	logic              in_range;
	logic              is_full;
	logic              push_ok;
	logic              pop_ok;
	logic [SLOT_W-1:0] h;
	logic [SLOT_W-1:0] t;
	logic [CNT_W-1:0]  c;
	logic [SLOT_W-1:0] h_inc;
	logic [SLOT_W-1:0] h_dec;
	logic [SLOT_W-1:0] t_inc;
	logic [SLOT_W-1:0] slot;
	status_t           st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= ACT_PUSH;
			prio_s1 <= '0;
			x_s1    <= '0;
			y_s1    <= '0;
		end else if (start) begin
			act_s1  <= action_t'(action);
			prio_s1 <= priority_req;
			x_s1    <= coord_x;
			y_s1    <= coord_y;
		end
	end

	// lowest non-empty bucket
	assign found   = |ne_q;
	assign low_hot = ne_q & (~ne_q + NUM_BUCKETS'(1));

	always_comb begin
		fb = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			if (low_hot[i]) begin
				fb = fb | BKT_W'(i);
			end
		end
	end

	assign in_range = {1'b0, prio_s1} < 9'(NUM_BUCKETS);
	assign sel      = (act_s1 == ACT_PUSH) ? prio_s1[BKT_W-1:0] : fb;
	assign h        = head_q[sel];
	assign t        = tail_q[sel];
	assign c        = cnt_q[sel];
	assign is_full  = c == CNT_W'(BUCKET_DEPTH);
	assign h_inc    = (h == SLOT_W'(BUCKET_DEPTH - 1)) ? '0 : h + SLOT_W'(1);
	assign h_dec    = (h == '0) ? SLOT_W'(BUCKET_DEPTH - 1) : h - SLOT_W'(1);
	assign t_inc    = (t == SLOT_W'(BUCKET_DEPTH - 1)) ? '0 : t + SLOT_W'(1);

	always_comb begin
		st      = ST_DONE;
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		slot    = h;
		unique case (act_s1)
			ACT_PUSH: begin
				if (!in_range) begin
					st = ST_RANGE;
				end else if (is_full) begin
					st = ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			ACT_POP_NEW: begin
				slot = h_dec;
				if (found) begin
					pop_ok = 1'b1;
				end else begin
					st = ST_EMPTY;
				end
			end
			ACT_POP_OLD: begin
				slot = t;
				if (found) begin
					pop_ok = 1'b1;
				end else begin
					st = ST_EMPTY;
				end
			end
			ACT_CLEAR: begin
				st = ST_DONE;
			end
			default: begin
				st = ST_DONE;
			end
		endcase
	end

	assign mem_req.we    = v_s1 && push_ok;
	assign mem_req.re    = v_s1 && pop_ok;
	assign mem_req.addr  = {sel, slot};
	assign mem_req.wdata = {COORD_BITS'(x_s1), COORD_BITS'(y_s1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			ne_q <= '0;
		end else if (v_s1) begin
			if (act_s1 == ACT_CLEAR) begin
				for (int i = 0; i < NUM_BUCKETS; i++) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
					cnt_q[i]  <= '0;
				end
				ne_q <= '0;
			end else if (push_ok) begin
				head_q[sel] <= h_inc;
				cnt_q[sel]  <= c + CNT_W'(1);
				ne_q[sel]   <= 1'b1;
			end else if (pop_ok) begin
				if (act_s1 == ACT_POP_NEW) begin
					head_q[sel] <= h_dec;
				end else begin
					tail_q[sel] <= t_inc;
				end
				cnt_q[sel] <= c - CNT_W'(1);
				ne_q[sel]  <= c != CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q.valid  <= v_s1;
			res_q.status <= st;
			res_q.pop_ok <= pop_ok;
			res_q.bucket <= sel;
		end
	end

	assign res = res_q;

	`BPD_ASSERT_NXT(a_result_follows, clk, arst_n, v_s1, res_q.valid)
	`BPD_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, c <= CNT_W'(BUCKET_DEPTH))
	`BPD_ASSERT_IMP(a_ne_matches_count, clk, arst_n, 1'b1, ne_q[sel] == (c != '0))
	`BPD_ASSERT_IMP(a_pop_nonempty, clk, arst_n, v_s1 && pop_ok, c != '0)

endmodule

`default_nettype wire
